[rtl/spn_pkg.sv]
// shared constants, codes and types for the spn cipher rounds unit
package spn_pkg;

   localparam int BLOCK_BYTES  = 16;
   localparam int NIBBLE_COUNT = 32;
   localparam int SBOX_ENTRIES = 256;
   localparam int BLOCK_BITS   = 8 * BLOCK_BYTES;
   localparam int NIB_IDX_W    = $clog2(NIBBLE_COUNT);
   localparam int ROUND_W      = 6;

   typedef enum logic [1:0] {
      OP_LOAD_SBOX = 2'd0,
      OP_LOAD_PERM = 2'd1,
      OP_ENCRYPT   = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // register indexes on the csr port
   localparam logic REG_ROUND_COUNT = 1'b0;
   localparam logic REG_PERM_PERIOD = 1'b1;

   localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 6'd16;
   localparam logic [ROUND_W-1:0] PERM_PERIOD_RESET = 6'd2;

   typedef logic [NIB_IDX_W-1:0] perm_table_type [NIBBLE_COUNT];

endpackage

[rtl/spn_ram.sv]
// generic single write port ram with registered read
module spn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/spn_perm.sv]
// nibble permutation network, highest source nibble wins on a shared target
module spn_perm (
   input  logic [spn_pkg::BLOCK_BITS-1:0] blk_in,
   input  spn_pkg::perm_table_type        perm,
   output logic [spn_pkg::BLOCK_BITS-1:0] blk_out
);

   import spn_pkg::*;

   // each target nibble picks the last source that maps onto it
   always_comb begin
      blk_out = '0;
      for (int j = 0; j < NIBBLE_COUNT; j++) begin
         for (int i = 0; i < NIBBLE_COUNT; i++) begin
            if (perm[i] == NIB_IDX_W'(j)) begin
               blk_out[BLOCK_BITS-1-4*j -: 4] = blk_in[BLOCK_BITS-1-4*i -: 4];
            end
         end
      end
   end

endmodule

[rtl/spn_block_cipher_rounds_unit.sv]
// top level of the spn cipher rounds unit
// An encrypt transfer runs round_count rounds from acceptance to the result
// (a block with zero rounds goes straight to the output): every round is one
// read of sixteen copies of the 256-entry substitution ram, one per byte, whose
// registered output passes through the nibble permutation when the permutation
// period is reached, and feeds the next read address. Table loads are accepted
// while a result waits on the output. One encrypt block is in flight at a time.
// Table contents are undefined until loaded; there is no clearing pass.
module spn_block_cipher_rounds_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_index,
   input  logic [7:0]  req_entry_value,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_cipher_hi,
   output logic [63:0] rsp_cipher_lo,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import spn_pkg::*;

   state_type              state_ff, state_in;
   logic [ROUND_W-1:0]     round_ff, round_in;
   logic [ROUND_W-1:0]     phase_ff, phase_in;
   logic [ROUND_W-1:0]     round_count_ff, perm_period_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_BITS-1:0]  cipher_ff, cipher_in;
   perm_table_type         perm_ff;
   logic [BLOCK_BITS-1:0]  sub_blk, perm_blk, mixed_blk, raddr_blk;
   logic [BLOCK_BITS-1:0]  req_blk;
   logic                   req_xfer, rsp_xfer, enc_xfer, csr_wr;
   logic                   do_perm, last_round;
   op_type                 op;

   assign op       = op_type'(req_op);
   assign req_blk  = {req_block_hi, req_block_lo};
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign req_xfer = req_valid && !req_stall;
   assign enc_xfer = req_xfer && (op == OP_ENCRYPT);

   // accept while idle; an encrypt also needs the output register free
   assign req_stall = (state_ff == ST_RUN) ||
                      (op == OP_ENCRYPT && rsp_valid_ff && rsp_stall);

   // csr port
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[2])
         REG_ROUND_COUNT: prdata = {26'd0, round_count_ff};
         default:         prdata = {26'd0, perm_period_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= ROUND_COUNT_RESET;
         perm_period_ff <= PERM_PERIOD_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_ROUND_COUNT) begin
            round_count_ff <= pwdata[ROUND_W-1:0];
         end else begin
            perm_period_ff <= pwdata[ROUND_W-1:0];
         end
      end
   end

   // permutation table loads, out-of-range positions dropped
   always_ff @(posedge clock) begin
      if (req_xfer && op == OP_LOAD_PERM && req_index < 8'(NIBBLE_COUNT)) begin
         perm_ff[req_index[NIB_IDX_W-1:0]] <= req_entry_value[NIB_IDX_W-1:0];
      end
   end

   // one substitution ram copy per byte lane
   for (genvar k = 0; k < BLOCK_BYTES; k++) begin : g_sbox
      spn_ram #(
         .WIDTH (8),
         .DEPTH (SBOX_ENTRIES)
      ) u_sbox (
         .clock (clock),
         .we    (req_xfer && op == OP_LOAD_SBOX),
         .waddr (req_index),
         .wdata (req_entry_value),
         .raddr (raddr_blk[BLOCK_BITS-1-8*k -: 8]),
         .rdata (sub_blk[BLOCK_BITS-1-8*k -: 8])
      );
   end

   spn_perm u_perm (
      .blk_in  (sub_blk),
      .perm    (perm_ff),
      .blk_out (perm_blk)
   );

   // round bookkeeping: phase counts rounds since the last permutation
   assign phase_in   = phase_ff + 1'b1;
   assign do_perm    = (phase_in == perm_period_ff);
   assign mixed_blk  = do_perm ? perm_blk : sub_blk;
   assign last_round = (round_ff == round_count_ff);
   assign raddr_blk  = (state_ff == ST_RUN) ? mixed_blk : req_blk;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (enc_xfer && round_count_ff != '0) state_in = ST_RUN;
         ST_RUN:  if (last_round) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output register control
   always_comb begin
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      cipher_in    = cipher_ff;
      unique case (state_ff)
         ST_IDLE: begin
            round_in = ROUND_W'(1);
            if (enc_xfer && round_count_ff == '0) begin
               rsp_valid_in = 1'b1;
               cipher_in    = req_blk;
            end
         end
         ST_RUN: begin
            round_in = round_ff + 1'b1;
            if (last_round) begin
               rsp_valid_in = 1'b1;
               cipher_in    = mixed_blk;
            end
         end
         default: round_in = ROUND_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= ROUND_W'(1);
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_RUN) begin
            phase_ff <= do_perm ? '0 : phase_in;
         end else begin
            phase_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cipher_ff <= cipher_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cipher_hi = cipher_ff[BLOCK_BITS-1 -: 64];
   assign rsp_cipher_lo = cipher_ff[63:0];

`ifndef NO_ASSERTIONS
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> round_ff != '0 && round_ff <= round_count_ff)
      else $error("round counter out of range");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> state_ff == ST_IDLE)
      else $error("input transfer while rounds run");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN) || $past(enc_xfer))
      else $error("result without a finished block");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && perm_period_ff != '0 |-> phase_ff < perm_period_ff)
      else $error("permutation phase out of range");
`endif

endmodule
